@@ hdl/rpn_stack_calculator_top_macros.svh @@
// Assertion macros for the calculator top level.
`ifndef RPN_STACK_CALCULATOR_TOP_MACROS_SVH
`define RPN_STACK_CALCULATOR_TOP_MACROS_SVH
`ifndef SYNTH
// Checked only while out of reset
`define RPN_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rpn_stack_calculator: assertion failed");
// Checked at every edge, reset included
`define RPN_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rpn_stack_calculator: assertion failed");
`else
`define RPN_ASSERT_RST(label, clk, rst_n, prop)
`define RPN_ASSERT(label, clk, prop)
`endif
`endif

@@ hdl/rpn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

    // Sizes
    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int BIT_W       = $clog2(DATA_W);
    localparam int REQ_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_W     = 5;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 3'd0,
        REQ_ADD   = 3'd1,
        REQ_SUB   = 3'd2,
        REQ_MUL   = 3'd3,
        REQ_DIV   = 3'd4,
        REQ_CLEAR = 3'd5
    } t_req;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_DIVZERO   = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    // Serial unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    // Command from the controller to the serial unit
    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_cmd;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_CALC
    } t_state;

    // Serial unit states
    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_FIN
    } t_alu_state;

endpackage

`default_nettype wire

@@ hdl/rpn_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Operand stack store: one write port, two registered read ports.
module rpn_stack (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [rpn_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [rpn_pkg::DATA_W-1:0]  i_wr_data,
    input  logic [rpn_pkg::ADDR_W-1:0]  i_rd_addr_a,
    input  logic [rpn_pkg::ADDR_W-1:0]  i_rd_addr_b,
    output logic [rpn_pkg::DATA_W-1:0]  o_rd_data_a,
    output logic [rpn_pkg::DATA_W-1:0]  o_rd_data_b
);
    import rpn_pkg::*;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read ports, registered
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

@@ hdl/rpn_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Serial arithmetic unit, one operand bit per cycle.
// Add/sub: bit-serial full adder, LSB first.
// Multiply: shift-and-add over the multiplier bits.
// Divide: restoring division on magnitudes, sign fixed in the last cycle.
module rpn_alu (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rpn_pkg::t_alu_cmd           i_cmd,
    input  logic [rpn_pkg::DATA_W-1:0]  i_lhs,
    input  logic [rpn_pkg::DATA_W-1:0]  i_rhs,
    output logic                        o_done,
    output logic [rpn_pkg::DATA_W-1:0]  o_result
);
    import rpn_pkg::*;

    t_alu_state        r_state, n_state;
    t_alu_op           r_op, n_op;
    logic [BIT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic              r_carry, n_carry;
    logic              r_neg, n_neg;
    logic              r_done, n_done;
    logic [DATA_W-1:0] r_res, n_res;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              sum_bit;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_cnt   <= n_cnt;
        r_a     <= n_a;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_carry <= n_carry;
        r_neg   <= n_neg;
        r_res   <= n_res;
    end

    // One step per cycle
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_carry = r_carry;
        n_neg   = r_neg;
        n_done  = 1'b0;
        n_res   = r_res;
        trial   = {r_acc, r_a[DATA_W-1]};
        diff    = trial - {1'b0, r_b};
        sum_bit = r_a[0] ^ r_b[0] ^ r_carry;

        case (r_state)
            A_IDLE: begin
                if (i_cmd.start) begin
                    n_state = A_RUN;
                    n_op    = i_cmd.op;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_a     = i_lhs;
                    n_b     = i_rhs;
                    n_carry = 1'b0;
                    n_neg   = i_lhs[DATA_W-1] ^ i_rhs[DATA_W-1];
                    case (i_cmd.op)
                        ALU_SUB: begin
                            n_b     = ~i_rhs;
                            n_carry = 1'b1;
                        end
                        ALU_DIV: begin
                            n_a = i_lhs[DATA_W-1] ? (~i_lhs + DATA_W'(1)) : i_lhs;
                            n_b = i_rhs[DATA_W-1] ? (~i_rhs + DATA_W'(1)) : i_rhs;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            A_RUN: begin
                case (r_op)
                    ALU_ADD, ALU_SUB: begin
                        n_acc   = {sum_bit, r_acc[DATA_W-1:1]};
                        n_carry = (r_a[0] & r_b[0]) | (r_carry & (r_a[0] ^ r_b[0]));
                        n_a     = r_a >> 1;
                        n_b     = r_b >> 1;
                    end
                    ALU_MUL: begin
                        if (r_b[0]) begin
                            n_acc = r_acc + r_a;
                        end
                        n_a = r_a << 1;
                        n_b = r_b >> 1;
                    end
                    default: begin
                        // restoring divide: quotient bits enter r_a from the bottom
                        if (!diff[DATA_W]) begin
                            n_acc = diff[DATA_W-1:0];
                            n_a   = {r_a[DATA_W-2:0], 1'b1};
                        end else begin
                            n_acc = trial[DATA_W-1:0];
                            n_a   = {r_a[DATA_W-2:0], 1'b0};
                        end
                    end
                endcase
                n_cnt = r_cnt + BIT_W'(1);
                if (r_cnt == BIT_W'(DATA_W - 1)) begin
                    n_state = A_FIN;
                end
            end
            A_FIN: begin
                if (r_op == ALU_DIV) begin
                    n_res = r_neg ? (~r_a + DATA_W'(1)) : r_a;
                end else begin
                    n_res = r_acc;
                end
                n_done  = 1'b1;
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

@@ hdl/rpn_stack_calculator_top.sv @@
// RPN integer calculator over a 16-entry stack. Raise start with a request
// while busy is low; exactly one result follows, shown for a single cycle
// with o_result_valid high, and it cannot be held off, so capture it then.
// o_stack_depth holds the depth after the last item. Push, clear, errors
// and unused codes are answered from the decode step alone; add,
// subtract, multiply and divide go to the bit-serial unit, which
// walks the 32 operand bits one per cycle between operand read and the
// sign fix and write-back. busy is low in the cycle that carries the result.
`timescale 1ns / 1ps
`default_nettype none
`include "rpn_stack_calculator_top_macros.svh"

module rpn_stack_calculator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [rpn_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [rpn_pkg::DATA_W-1:0]  i_push_value,
    output logic                               o_result_valid,
    output logic signed [rpn_pkg::DATA_W-1:0]  o_result_value,
    output logic [rpn_pkg::STATUS_W-1:0]       o_status,
    output logic [rpn_pkg::DEPTH_W-1:0]        o_stack_depth
);
    import rpn_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_top, n_top;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_result, n_result;
    t_status           r_status, n_status;
    logic [REQ_W-1:0]  r_req;
    logic [DATA_W-1:0] r_push;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] lhs;
    t_alu_cmd          alu_cmd;
    logic              alu_done;
    logic [DATA_W-1:0] alu_result;
    logic              accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Top entry and the one below it are read continuously
    assign rd_addr_a = ADDR_W'(r_top - CNT_W'(1));
    assign rd_addr_b = ADDR_W'(r_top - CNT_W'(2));

    rpn_stack u_stack (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rhs),
        .o_rd_data_b (lhs)
    );

    rpn_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (alu_cmd),
        .i_lhs    (lhs),
        .i_rhs    (rhs),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
    end

    // Request capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_push <= i_push_value;
        end
        r_result <= n_result;
        r_status <= n_status;
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_top        = r_top;
        n_out_valid  = 1'b0;
        n_result     = r_result;
        n_status     = r_status;
        wr_en        = 1'b0;
        wr_addr      = ADDR_W'(r_top);
        wr_data      = r_push;
        alu_cmd      = '{start: 1'b0, op: ALU_ADD};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_result    = '0;
                n_status    = STAT_OK;
                case (r_req)
                    REQ_PUSH: begin
                        if (r_top >= CNT_W'(STACK_DEPTH)) begin
                            n_status = STAT_FULL;
                        end else begin
                            wr_en    = 1'b1;
                            n_top    = r_top + CNT_W'(1);
                            n_result = r_push;
                        end
                    end
                    REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
                        if (r_top < CNT_W'(2)) begin
                            n_status = STAT_UNDERFLOW;
                        end else if (r_req == REQ_DIV && rhs == '0) begin
                            n_status = STAT_DIVZERO;
                        end else begin
                            // hand the two operands to the serial unit
                            n_state       = S_CALC;
                            n_out_valid   = 1'b0;
                            alu_cmd.start = 1'b1;
                            case (r_req)
                                REQ_SUB: alu_cmd.op = ALU_SUB;
                                REQ_MUL: alu_cmd.op = ALU_MUL;
                                REQ_DIV: alu_cmd.op = ALU_DIV;
                                default: alu_cmd.op = ALU_ADD;
                            endcase
                        end
                    end
                    REQ_CLEAR: begin
                        n_top = '0;
                    end
                    default: begin
                        // unused codes: stack left as is
                    end
                endcase
            end
            S_CALC: begin
                // result replaces the two operands
                wr_addr = rd_addr_b;
                wr_data = alu_result;
                if (alu_done) begin
                    wr_en       = 1'b1;
                    n_top       = r_top - CNT_W'(1);
                    n_result    = alu_result;
                    n_status    = STAT_OK;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result_valid = r_out_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;
    assign o_stack_depth  = DEPTH_W'(r_top);

    // Checks
    `RPN_ASSERT_RST(a_strobe_when_idle, i_clk, i_rst_n, r_out_valid |-> !busy)
    `RPN_ASSERT_RST(a_depth_bound, i_clk, i_rst_n, r_top <= CNT_W'(STACK_DEPTH))
    `RPN_ASSERT_RST(a_full_depth, i_clk, i_rst_n, (r_out_valid && r_status == STAT_FULL) |-> (r_top == CNT_W'(STACK_DEPTH)))
    `RPN_ASSERT_RST(a_alu_done_in_calc, i_clk, i_rst_n, alu_done |-> (r_state == S_CALC))
    `RPN_ASSERT(a_reset_clears, i_clk, !i_rst_n |=> (!r_out_valid && !busy))

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import rpn_pkg::*;

    // Unused request codes, accepted and ignored by the block
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_GAP      = 8;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic [DEPTH_W-1:0]       depth;
    } calc_result_t;

    // Stack predictor and store of expected results
    class calc_scoreboard;
        logic signed [DATA_W-1:0] operands [STACK_DEPTH];
        int unsigned              depth;
        calc_result_t             expected_q[$];
        int unsigned              errors;
        int unsigned              reported;

        function new();
            depth    = 0;
            errors   = 0;
            reported = 0;
        endfunction

        // Work out the result of one accepted item and queue it
        function void note_item(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] value);
            calc_result_t             exp_res;
            logic signed [DATA_W-1:0] lhs;
            logic signed [DATA_W-1:0] rhs;
            longint                   quot;
            exp_res.value  = '0;
            exp_res.status = STAT_OK;
            case (req)
                REQ_PUSH: begin
                    if (depth >= STACK_DEPTH) begin
                        exp_res.status = STAT_FULL;
                    end else begin
                        operands[depth] = value;
                        depth++;
                        exp_res.value = value;
                    end
                end
                REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
                    if (depth < 2) begin
                        exp_res.status = STAT_UNDERFLOW;
                    end else begin
                        rhs = operands[depth-1];
                        lhs = operands[depth-2];
                        if (req == REQ_DIV && rhs == 0) begin
                            exp_res.status = STAT_DIVZERO;
                        end else begin
                            case (req)
                                REQ_ADD: exp_res.value = lhs + rhs;
                                REQ_SUB: exp_res.value = lhs - rhs;
                                REQ_MUL: exp_res.value = lhs * rhs;
                                default: begin
                                    // 64-bit divide: most negative over minus one wraps
                                    quot = longint'(lhs) / longint'(rhs);
                                    exp_res.value = quot[DATA_W-1:0];
                                end
                            endcase
                            depth--;
                            operands[depth-1] = exp_res.value;
                        end
                    end
                end
                REQ_CLEAR: depth = 0;
                default: ;
            endcase
            exp_res.depth = depth[DEPTH_W-1:0];
            expected_q.push_back(exp_res);
        endfunction

        function void flag(string msg);
            errors++;
            if (reported < 10) begin
                reported++;
                $display("%0t: %s", $realtime, msg);
            end
        endfunction

        // Compare one result against the oldest expectation
        function void check_result(logic signed [DATA_W-1:0] value, logic [STATUS_W-1:0] status,
                                   logic [DEPTH_W-1:0] stack_depth);
            calc_result_t exp_res;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result value %0d status %0d depth %0d",
                               value, status, stack_depth));
            end else begin
                exp_res = expected_q.pop_front();
                if (value !== exp_res.value || status !== exp_res.status
                        || stack_depth !== exp_res.depth)
                    flag($sformatf("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                   exp_res.value, exp_res.status, exp_res.depth,
                                   value, status, stack_depth));
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [REQ_W-1:0]             i_req_type = '0;
    logic signed [DATA_W-1:0]     i_push_value = '0;
    logic                         o_result_valid;
    logic signed [DATA_W-1:0]     o_result_value;
    logic [STATUS_W-1:0]          o_status;
    logic [DEPTH_W-1:0]           o_stack_depth;

    calc_scoreboard sb;
    int             stall_cycles;
    int unsigned    shadow_depth;

    rpn_stack_calculator_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_push_value   (i_push_value),
        .o_result_valid (o_result_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_stack_depth  (o_stack_depth)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Monitor: result of an earlier item is checked before a new item is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid)
                sb.check_result(o_result_value, o_status, o_stack_depth);
            if (start && !busy)
                sb.note_item(i_req_type, i_push_value);
        end
    end

    // Watchdog on cycles with no progress at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Offer one item and return at the edge that accepts it; start stays high
    task automatic send_item(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] value);
        start        <= 1'b1;
        i_req_type   <= req;
        i_push_value <= value;
        do
            @(posedge i_clk);
        while (busy);
        case (req)
            REQ_PUSH: if (shadow_depth < STACK_DEPTH) shadow_depth++;
            REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: if (shadow_depth >= 2) shadow_depth--;
            REQ_CLEAR: shadow_depth = 0;
            default: ;
        endcase
    endtask

    // Sender gap of random length, taken with the given probability
    task automatic maybe_idle(int idle_pct);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom;
        if (sel < 7)
            return int'($urandom_range(0, 32)) - 16;
        case ($urandom_range(0, 4))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return -1;
            3:       return 0;
            default: return 1;
        endcase
    endfunction

    // Random items biased towards deep, well-formed stack use
    task automatic run_random(int n_items, int idle_pct);
        int              sent;
        int              r;
        logic [REQ_W-1:0] req;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                req = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
            end else if (r < 6) begin
                req = REQ_CLEAR;
            end else if (r < 9) begin
                req = t_req'($urandom_range(REQ_ADD, REQ_DIV));
            end else if (shadow_depth < 2 || (shadow_depth < STACK_DEPTH && r < 62)) begin
                req = REQ_PUSH;
            end else if (shadow_depth == STACK_DEPTH && r < 20) begin
                req = REQ_PUSH;
            end else begin
                req = t_req'($urandom_range(REQ_ADD, REQ_DIV));
            end
            send_item(req, req == REQ_PUSH ? pick_operand() : $urandom);
            if (req != REQ_SPARE_LO && req != REQ_SPARE_HI)
                sent++;
            maybe_idle(idle_pct);
        end
    endtask

    initial begin
        int idle_plan [4];
        sb           = new();
        shadow_depth = 0;
        idle_plan    = '{0, 51, 0, 33};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: underflow, wrap, divide corner cases, spare codes, full stack
        send_item(REQ_ADD, 0);
        send_item(REQ_DIV, VAL_MAX);
        send_item(REQ_PUSH, VAL_MAX);
        send_item(REQ_SUB, 0);
        send_item(REQ_PUSH, 1);
        send_item(REQ_ADD, 0);
        send_item(REQ_PUSH, -1);
        send_item(REQ_DIV, 0);
        send_item(REQ_PUSH, 0);
        send_item(REQ_DIV, 0);
        send_item(REQ_MUL, 0);
        send_item(REQ_SPARE_LO, VAL_MIN);
        send_item(REQ_SPARE_HI, -1);
        send_item(REQ_PUSH, -7);
        send_item(REQ_PUSH, 2);
        send_item(REQ_DIV, 0);
        send_item(REQ_SUB, 0);
        while (shadow_depth < STACK_DEPTH)
            send_item(REQ_PUSH, pick_operand());
        send_item(REQ_PUSH, VAL_MIN);
        send_item(REQ_CLEAR, VAL_MAX);

        // Random phases with different sender idling
        foreach (idle_plan[p])
            run_random(ITEMS_PER_PHASE, idle_plan[p]);
        start <= 1'b0;

        // Drain, then let the block settle
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
